>>> rtl/encoder_angle_glitch_velocity_tracker_macros.svh
// Assertion helpers for the encoder tracker checker.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef ENCODER_ANGLE_GLITCH_VELOCITY_TRACKER_MACROS_SVH
`define ENCODER_ANGLE_GLITCH_VELOCITY_TRACKER_MACROS_SVH

// Condition at one edge implies a property at the next, outside reset.
`define EAGVT_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("eagvt: sequencing check failed");

// Property that must hold in the cycle after a reset edge.
`define EAGVT_ASSERT_RESET(lbl, prop) \
  lbl: assert property (@(posedge clk) !rst_n |=> (prop)) \
    else $error("eagvt: reset check failed");

`endif

>>> rtl/eagvt_pkg.sv
package eagvt_pkg;

  localparam int WINDOW     = 50;
  localparam int ANGLE_BITS = 16;

  // window counter width: the count stays below WINDOW
  localparam int CNT_W     = $clog2(WINDOW);
  localparam int STEP_W    = 24;
  // window average by reciprocal: shift and reciprocal width for an exact quotient
  localparam int DIV_SH    = STEP_W + $clog2(WINDOW - 1);
  localparam int RCP_W     = STEP_W + 1;
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    REG_POLE_PAIRS = 2'd0,
    REG_GLITCH_THR = 2'd1,
    REG_EXTRAP_GAIN = 2'd2,
    REG_VEL_SCALE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_E,
    S_CHECK,
    S_UPDATE,
    S_DIV,
    S_MUL_V,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_ELEC,
    MUL_EXTRAP,
    MUL_VEL
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     check;
    logic     update;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic win_close;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/eagvt_ctrl.sv
module eagvt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  eagvt_pkg::dp_sts_t sts,
  output eagvt_pkg::dp_cmd_t cmd
);
  import eagvt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_MUL_E;
      S_MUL_E:  state_nxt = S_CHECK;
      S_CHECK:  state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = sts.win_close ? S_DIV : S_MUL_V;
      S_DIV:    if (sts.div_done) state_nxt = S_MUL_V;
      S_MUL_V:  state_nxt = S_DONE;
      S_DONE:   if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.mul_sel  = MUL_ELEC;
    cmd.check    = 1'b0;
    cmd.update   = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_MUL_E: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ELEC;
      end
      S_CHECK: begin
        // classify the sample while the extrapolation step is formed
        cmd.check   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_EXTRAP;
      end
      S_UPDATE: cmd.update = 1'b1;
      S_DIV:    ;
      S_MUL_V: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VEL;
      end
      S_DONE:   cmd.load_out = sts.out_free;
      default:  ;
    endcase
  end

endmodule

>>> rtl/eagvt_div.sv
module eagvt_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [eagvt_pkg::STEP_W-1:0] dividend,
  output logic                                done,
  output logic signed [eagvt_pkg::STEP_W-1:0] quot
);
  import eagvt_pkg::*;

  // ceil(2^DIV_SH / (WINDOW-1)): the floored product is the exact truncated
  // quotient for every magnitude the window sum can take
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << DIV_SH) + 64'(WINDOW - 2)) / 64'(WINDOW - 1));

  logic signed [STEP_W-1:0] num_r;
  logic                     stg_r;
  logic                     done_r;
  logic [STEP_W+RCP_W-1:0]  prod_r;

  logic [STEP_W-1:0]        mag;
  logic [STEP_W-1:0]        q_mag;

  // magnitude of the most negative sum wraps to its correct unsigned pattern
  assign mag = unsigned'((num_r < 0) ? -num_r : num_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      stg_r  <= start;
      done_r <= stg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) num_r <= dividend;
    if (stg_r) prod_r <= mag * RECIP;
  end

  assign q_mag = STEP_W'(prod_r[STEP_W+RCP_W-1:DIV_SH]);

  assign done = done_r;
  assign quot = num_r[STEP_W-1] ? -signed'(q_mag) : signed'(q_mag);

endmodule

>>> rtl/eagvt_dp.sv
module eagvt_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  eagvt_pkg::cfg_reg_t      cfg_index,
  input  logic [15:0]              cfg_wdata,
  input  logic [15:0]              in_mech_angle,
  input  logic                     out_ready,
  input  eagvt_pkg::dp_cmd_t       cmd,
  output eagvt_pkg::dp_sts_t       sts,
  output logic                     out_valid,
  output logic signed [15:0]       out_elec_angle,
  output logic                     out_glitch,
  output logic signed [31:0]       out_velocity,
  output logic                     out_velocity_new
);
  import eagvt_pkg::*;

  localparam int AB    = ANGLE_BITS;
  localparam int CMP_W = ((AB > 15) ? AB : 15) + 3;
  localparam int SUM_W = STEP_W + 1;
  localparam int AFULL = 1 << AB;
  localparam logic [AB-1:0] AHALF = {1'b1, {(AB - 1){1'b0}}};
  localparam logic signed [CMP_W-1:0] FULL_C = CMP_W'(AFULL);
  localparam logic signed [PROD_W-1:0] VEL_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] VEL_MIN = PROD_W'(-64'sd2147483648);
  localparam logic signed [SUM_W-1:0] STEP_MAX = SUM_W'({1'b0, {(STEP_W - 1){1'b1}}});
  localparam logic signed [SUM_W-1:0] STEP_MIN = -STEP_MAX - SUM_W'(1);

  function automatic logic signed [STEP_W-1:0] sat_step(input logic signed [SUM_W-1:0] v);
    logic signed [STEP_W-1:0] r;
    if (v > STEP_MAX) r = STEP_MAX[STEP_W-1:0];
    else if (v < STEP_MIN) r = STEP_MIN[STEP_W-1:0];
    else r = v[STEP_W-1:0];
    return r;
  endfunction

  // configuration
  logic [5:0]  pole_pairs_r;
  logic [14:0] thr_r;
  logic [15:0] gain_r;
  logic [15:0] scale_r;

  // tracker state
  logic [AB-1:0]            last_r;
  logic signed [STEP_W-1:0] vstep_r;
  logic signed [STEP_W-1:0] sum_r;
  logic [CNT_W-1:0]         wc_r;

  // per-word working registers
  logic [AB-1:0]            mech_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [AB-1:0]            ang_r;
  logic                     glitch_r;
  logic                     vnew_r;

  // output register
  logic                     out_valid_r;
  logic [15:0]              out_ang_r;
  logic                     out_glitch_r;
  logic signed [31:0]       out_vel_r;
  logic                     out_vnew_r;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod;

  logic [AB-1:0]            elec;
  logic signed [CMP_W-1:0]  d;
  logic signed [CMP_W-1:0]  err;
  logic signed [CMP_W-1:0]  thr_s;
  logic signed [CMP_W-1:0]  upper;
  logic                     glitch_c;

  logic [AB-1:0]            a_fin;
  logic [AB-1:0]            diff_u;
  logic signed [AB-1:0]     wd;
  logic signed [SUM_W-1:0]  sum_ext;
  logic signed [STEP_W-1:0] sum_new;
  logic [CNT_W:0]           wc_inc;
  logic                     win_close;

  logic                     div_done;
  logic signed [STEP_W-1:0] div_q;
  logic signed [31:0]       vel_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_pairs_r <= 6'd1;
      thr_r        <= 15'd3641;
      gain_r       <= 16'd256;
      scale_r      <= 16'd36000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLE_PAIRS:  pole_pairs_r <= cfg_wdata[5:0];
        REG_GLITCH_THR:  thr_r        <= cfg_wdata[14:0];
        REG_EXTRAP_GAIN: gain_r       <= cfg_wdata;
        REG_VEL_SCALE:   scale_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_ELEC: begin
        op_a = signed'(MUL_A_W'(mech_r));
        op_b = signed'(MUL_B_W'(pole_pairs_r));
      end
      MUL_EXTRAP: begin
        op_a = MUL_A_W'(vstep_r);
        op_b = signed'(MUL_B_W'(gain_r));
      end
      MUL_VEL: begin
        op_a = MUL_A_W'(vstep_r);
        op_b = signed'(MUL_B_W'(scale_r));
      end
      default: begin
        op_a = signed'(MUL_A_W'(mech_r));
        op_b = signed'(MUL_B_W'(pole_pairs_r));
      end
    endcase
  end

  assign prod = op_a * op_b;

  // glitch test on the plain, unwrapped jump
  assign elec     = prod_r[AB-1:0] ^ AHALF;
  assign d        = CMP_W'(signed'(elec)) - CMP_W'(signed'(last_r));
  assign err      = (d < 0) ? -d : d;
  assign thr_s    = signed'(CMP_W'(thr_r));
  assign upper    = FULL_C - thr_s;
  assign glitch_c = (err > thr_s) && (err < upper);

  // window accumulation on the wrapped difference
  assign a_fin     = glitch_r ? (last_r + prod_r[AB+7:8]) : ang_r;
  assign diff_u    = a_fin - last_r;
  assign wd        = signed'(diff_u);
  assign sum_ext   = SUM_W'(sum_r) + SUM_W'(wd);
  assign sum_new   = (wc_r != '0) ? sat_step(sum_ext) : sum_r;
  assign wc_inc    = (CNT_W + 1)'(wc_r) + (CNT_W + 1)'(1);
  assign win_close = (wc_inc >= (CNT_W + 1)'(WINDOW));

  always_ff @(posedge clk) begin
    if (cmd.load_in) mech_r <= AB'(in_mech_angle);
    if (cmd.mul_en) prod_r <= prod;
    if (cmd.check) begin
      ang_r    <= elec;
      glitch_r <= glitch_c;
    end else if (cmd.update) begin
      ang_r  <= a_fin;
      vnew_r <= win_close;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      vstep_r <= '0;
      sum_r   <= '0;
      wc_r    <= '0;
    end else begin
      if (cmd.update) begin
        last_r <= a_fin;
        if (win_close) begin
          sum_r <= '0;
          wc_r  <= '0;
        end else begin
          sum_r <= sum_new;
          wc_r  <= wc_inc[CNT_W-1:0];
        end
      end
      if (div_done) vstep_r <= div_q;
    end
  end

  eagvt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.update && win_close),
    .dividend (sum_new),
    .done     (div_done),
    .quot     (div_q)
  );

  always_comb begin
    if (prod_r > VEL_MAX) vel_sat = VEL_MAX[31:0];
    else if (prod_r < VEL_MIN) vel_sat = VEL_MIN[31:0];
    else vel_sat = prod_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ang_r    <= 16'(ang_r);
      out_glitch_r <= glitch_r;
      out_vel_r    <= vel_sat;
      out_vnew_r   <= vnew_r;
    end
  end

  assign sts.win_close = win_close;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_elec_angle   = signed'(out_ang_r);
  assign out_glitch       = out_glitch_r;
  assign out_velocity     = out_vel_r;
  assign out_velocity_new = out_vnew_r;

endmodule

>>> rtl/encoder_angle_glitch_velocity_tracker.sv
// Encoder angle glitch filter and velocity tracker.
//
// Input channel (in_valid/in_ready, in_mech_angle): one mechanical angle word
// per control tick, an unsigned fraction of a turn. Output channel
// (out_valid/out_ready): per input word one result word with the stored
// electrical angle, the glitch flag, the velocity estimate and a flag that
// marks the word which closed an averaging window.
// Configuration (cfg_we/cfg_index/cfg_wdata): single-cycle writes of pole
// pairs, glitch threshold, extrapolation gain and velocity scale; write only
// while no word is in flight.
// Sequencing: one word is worked on at a time, and out_valid rises when its
// result is loaded into the output register; the one multiplier is used
// three times in turn (angle scaling, extrapolation step, velocity scaling).
// Every WINDOW-th word also averages the window sum by a reciprocal multiply
// in a two-stage divider before the velocity scaling.
// The output register lets the next word be taken while a result waits; if
// the receiver stalls, the following result holds in the datapath and
// in_ready stays low until the output register frees up.
// Reset (synchronous, rst_n low): registers return to their defaults, angle,
// velocity step, window sum and count clear, and the output register empties.
module encoder_angle_glitch_velocity_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  eagvt_pkg::cfg_reg_t  cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          in_mech_angle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_elec_angle,
  output logic                 out_glitch,
  output logic signed [31:0]   out_velocity,
  output logic                 out_velocity_new
);
  import eagvt_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: steps one word through scale, check, update, average, output
  eagvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: configuration, tracker state, shared multiplier, divider and
  // the output register
  eagvt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_mech_angle    (in_mech_angle),
    .out_ready        (out_ready),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_elec_angle   (out_elec_angle),
    .out_glitch       (out_glitch),
    .out_velocity     (out_velocity),
    .out_velocity_new (out_velocity_new)
  );

endmodule

>>> rtl/eagvt_chk.sv
`include "encoder_angle_glitch_velocity_tracker_macros.svh"

module eagvt_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // reset leaves the block empty and ready for a word
  `EAGVT_ASSERT_RESET(a_reset_empty, in_ready && !out_valid)

  // one word at a time: the input closes right after it takes a word
  `EAGVT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // a stalled result is held
  `EAGVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind encoder_angle_glitch_velocity_tracker eagvt_chk u_eagvt_chk (.*);

>>> sim/tb_encoder_angle_glitch_velocity_tracker.sv
`timescale 1ns / 1ps

module tb_encoder_angle_glitch_velocity_tracker;
  import eagvt_pkg::*;

  // Idle cycles after the last result before a register write or the verdict.
  // A window-closing word takes longest, as it also passes the divider; leave some margin on top.
  localparam int SETTLE_CYCLES = 40;
  localparam int DIR_ROWS      = 17;
  localparam int PHASE_WORDS   = 38;
  localparam int NUM_PHASES    = 7;

  // One result word: angle, reject flag, velocity, window-closed flag
  typedef struct packed {
    logic signed [15:0] elec;
    logic               glitch;
    logic signed [31:0] vel;
    logic               vnew;
  } tracker_out_t;

  // Directed word: a known result is typed in only where it is obvious
  typedef struct packed {
    logic [15:0]  mech;
    logic         known;
    tracker_out_t want;
  } dir_row_t;

  // Reset registers, first window: the velocity step is still zero, so every
  // typed row expects velocity 0 and no window close.
  localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
    '{16'h8000, 1'b1, '{16'sd0,    1'b0, 32'sd0, 1'b0}}, // mid-scale: zero electrical angle
    '{16'h0000, 1'b1, '{16'sd0,    1'b1, 32'sd0, 1'b0}}, // half-turn jump: reject, hold angle
    '{16'hFFFF, 1'b1, '{16'sd0,    1'b1, 32'sd0, 1'b0}}, // top of scale: reject
    '{16'h8E39, 1'b1, '{16'sd3641, 1'b0, 32'sd0, 1'b0}}, // jump exactly at threshold: keep
    '{16'h9C73, 1'b1, '{16'sd3641, 1'b1, 32'sd0, 1'b0}}, // one over threshold: reject
    '{16'h9C72, 1'b1, '{16'sd7282, 1'b0, 32'sd0, 1'b0}}, // at threshold from new base
    '{16'h7FFF, 1'b1, '{16'sd7282, 1'b1, 32'sd0, 1'b0}}, // negative jump: reject
    // climb towards plus half a turn in steps below the threshold
    '{16'd43050, 1'b0, '0},
    '{16'd46050, 1'b0, '0},
    '{16'd49050, 1'b0, '0},
    '{16'd52050, 1'b0, '0},
    '{16'd55050, 1'b0, '0},
    '{16'd58050, 1'b0, '0},
    '{16'd61050, 1'b0, '0},
    '{16'd64050, 1'b0, '0},
    // cross the half-turn seam: huge plain difference that still passes
    '{16'd768,   1'b0, '0},
    '{16'd3768,  1'b0, '0}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_reg_t            cfg_index;
  logic [15:0]         cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [15:0]         in_mech_angle;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [15:0]  out_elec_angle;
  logic                out_glitch;
  logic signed [31:0]  out_velocity;
  logic                out_velocity_new;

  // Shadow of the register file as the tracker sees it
  logic [5:0]  pole_pairs_q;
  logic [14:0] thr_q;
  logic [15:0] gain_q;
  logic [15:0] scale_q;

  // Shadow of the tracker state
  logic [15:0] last_ang;
  int          vstep;
  int          dsum;
  int          wcount;

  tracker_out_t angle_results_due[$];
  tracker_out_t got_word;
  tracker_out_t due_word;
  int          bad_words = 0;
  int          words_out = 0;
  int          burst_left = 0;

  // Receiver stall pattern state
  int          ready_mode = 0;
  int          ready_left = 0;
  int          ready_tick = 0;

  // Random track state
  logic [15:0] track_pos;
  int          track_speed;
  int          step_max;
  int          pp_eff;
  int          pick;

  encoder_angle_glitch_velocity_tracker i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mech_angle    (in_mech_angle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_elec_angle   (out_elec_angle),
    .out_glitch       (out_glitch),
    .out_velocity     (out_velocity),
    .out_velocity_new (out_velocity_new)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int clamp24(longint v);
    if (v > 64'sd8388607) return 8388607;
    if (v < -64'sd8388608) return -8388608;
    return int'(v);
  endfunction

  // Advance the shadow state by one angle word and return its result word
  function automatic tracker_out_t track_angle(logic [15:0] mech);
    logic [21:0]  scaled;
    logic [15:0]  ang;
    logic [15:0]  delta;
    int           jump;
    int           mag;
    longint       extr;
    longint       vel;
    tracker_out_t r;
    scaled = mech * pole_pairs_q;
    // drop the turn count, then shift by half a turn to centre on zero
    ang  = scaled[15:0] ^ 16'h8000;
    jump = int'($signed(ang)) - int'($signed(last_ang));
    mag  = (jump < 0) ? -jump : jump;
    r.glitch = (mag > int'(thr_q)) && (mag < 65536 - int'(thr_q));
    if (r.glitch) begin
      // extrapolate: previous angle plus gained step, Q8.8 gain floored
      extr = longint'(vstep) * longint'(gain_q);
      ang  = last_ang + extr[23:8];
    end
    if (wcount > 0) begin
      delta = ang - last_ang;
      dsum  = clamp24(longint'(dsum) + longint'($signed(delta)));
    end
    wcount++;
    r.vnew = 1'b0;
    if (wcount >= WINDOW) begin
      vstep  = clamp24(longint'(dsum / (WINDOW - 1)));
      dsum   = 0;
      wcount = 0;
      r.vnew = 1'b1;
    end
    last_ang = ang;
    vel = longint'(vstep) * longint'(scale_q);
    if (vel > 64'sd2147483647) vel = 64'sd2147483647;
    if (vel < -64'sd2147483648) vel = -64'sd2147483648;
    r.vel  = vel[31:0];
    r.elec = ang;
    return r;
  endfunction

  // Offer one angle word; sender idles for a random gap, sometimes none, between bursts of random length
  task automatic send_word(input logic [15:0] ang, input logic known,
                           input tracker_out_t typed);
    int           gap;
    tracker_out_t r;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_mech_angle <= ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = track_angle(ang);
    angle_results_due.push_back(known ? typed : r);
    burst_left--;
  endtask

  // Wait for every outstanding result, then let the datapath settle
  task automatic drain();
    while (angle_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_POLE_PAIRS:  pole_pairs_q = val[5:0];
      REG_GLITCH_THR:  thr_q = val[14:0];
      REG_EXTRAP_GAIN: gain_q = val;
      default:         scale_q = val;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] pp, input logic [15:0] thr,
                          input logic [15:0] gain, input logic [15:0] scale);
    write_reg(REG_POLE_PAIRS, pp);
    write_reg(REG_GLITCH_THR, thr);
    write_reg(REG_EXTRAP_GAIN, gain);
    write_reg(REG_VEL_SCALE, scale);
    cfg_we <= 1'b0;
  endtask

  // Receiver: switch at random between stall patterns, and check
  // each accepted result word against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(16, 160);
    end else begin
      ready_left <= ready_left - 1;
    end
    ready_tick <= ready_tick + 1;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (ready_tick % 5 != 0);
    endcase

    if (rst_n && out_valid && out_ready) begin
      got_word = '{out_elec_angle, out_glitch, out_velocity, out_velocity_new};
      words_out++;
      if (angle_results_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10) $display("word %0d: result with none outstanding", words_out);
      end else begin
        due_word = angle_results_due.pop_front();
        if (got_word.elec !== due_word.elec || got_word.glitch !== due_word.glitch ||
            got_word.vel !== due_word.vel || got_word.vnew !== due_word.vnew) begin
          bad_words++;
          if (bad_words <= 10)
            $display("word %0d: exp angle %0d glitch %0b vel %0d new %0b, got %0d %0b %0d %0b",
                     words_out, due_word.elec, due_word.glitch, due_word.vel, due_word.vnew,
                     got_word.elec, got_word.glitch, got_word.vel, got_word.vnew);
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_POLE_PAIRS;
    cfg_wdata     = 16'd0;
    in_valid      = 1'b0;
    in_mech_angle = 16'd0;
    // register defaults and cleared state, as after reset
    pole_pairs_q = 6'd1;
    thr_q        = 15'd3641;
    gain_q       = 16'd256;
    scale_q      = 16'd36000;
    last_ang     = 16'd0;
    vstep        = 0;
    dsum         = 0;
    wcount       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words on the reset register values
    for (int n = 0; n < DIR_ROWS; n++)
      send_word(DIRECTED[n].mech, DIRECTED[n].known, DIRECTED[n].want);
    in_valid <= 1'b0;
    drain();

    // Steady rotation at 256 per word for two windows: one whole window lies
    // inside, so the velocity step settles at 256. Start on the held angle.
    set_regs(16'd1, 16'd3641, 16'd32768, 16'd36000);
    track_pos = last_ang ^ 16'h8000;
    for (int n = 0; n < 2 * WINDOW; n++) begin
      send_word(track_pos, 1'b0, '0);
      track_pos = track_pos + 16'd256;
    end
    in_valid <= 1'b0;
    drain();

    // Zero threshold rejects any move; gain 128 on a step of 256 gives an
    // extrapolation of exactly half a turn, which the sum must count as negative.
    set_regs(16'd1, 16'd0, 16'd32768, 16'd36000);
    for (int n = 0; n < 15; n++)
      send_word(16'($urandom), 1'b0, '0);
    in_valid <= 1'b0;
    drain();

    // Random phases: mostly smooth tracks with random speed, some speed
    // changes and some wild samples, over a spread of register settings.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: set_regs(16'd0, 16'($urandom), 16'($urandom), 16'($urandom));
        1: set_regs(16'd32, 16'd32767, 16'd65535, 16'd65535);
        2: set_regs(16'd1, 16'($urandom_range(500, 6000)), 16'd0, 16'd0);
        3: set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        5: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: set_regs(16'd1, 16'($urandom_range(200, 12000)), 16'($urandom),
                          16'($urandom));
      endcase
      // keep the electrical step mostly below the threshold
      pp_eff   = (pole_pairs_q == 6'd0) ? 1 : int'(pole_pairs_q);
      step_max = int'(thr_q) / pp_eff / 2;
      if (step_max < 1) step_max = 1;
      if (step_max > 4000) step_max = 4000;
      // with one pole pair, pick up the track where the held angle is
      track_pos   = (pole_pairs_q == 6'd1) ? (last_ang ^ 16'h8000) : 16'($urandom);
      track_speed = int'($urandom_range(0, 2 * step_max)) - step_max;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) track_speed = int'($urandom_range(0, 2 * step_max)) - step_max;
        track_pos = track_pos + 16'(track_speed);
        send_word((pick >= 92) ? 16'($urandom) : track_pos, 1'b0, '0);
      end
      in_valid <= 1'b0;
      drain();
    end

    if (bad_words == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
